>>> design/mtfd_pkg.sv
// mtfd_pkg: shared types, constants and helper functions for the
// multi-tap frame delay slot controller. No dependencies.

package mtfd_pkg;

   localparam int NUM_RINGS = 6;
   localparam int MAX_DELAY = 400;
   localparam int SLOT_W    = 9;
   localparam int MASK_W    = NUM_RINGS;
   localparam int SEL_W     = 3;
   localparam int CMD_W     = 2;
   localparam int DATA_W    = 32;
   localparam int ADDR_W    = 5;
   localparam int INDEX_W   = ADDR_W - 2;

   typedef logic [SLOT_W-1:0]  slot_type;
   typedef logic [CMD_W-1:0]   cmd_type;
   typedef logic [INDEX_W-1:0] reg_index_type;

   // request codes; anything else passes through
   localparam cmd_type CMD_STORE = 2'd1;
   localparam cmd_type CMD_FETCH = 2'd2;

   // register map: delay registers take indexes below the mask register
   localparam reg_index_type REG_BEAT_FOLLOW_MASK = reg_index_type'(NUM_RINGS);

   localparam slot_type MAX_SLOT = slot_type'(MAX_DELAY);

   typedef struct packed {
      logic       new_frame;
      logic       beat;
      logic       geometry_changed;
      logic       geometry_valid;
      cmd_type    cmd;
      logic [SEL_W-1:0] buffer_sel;
   } req_type;

   typedef struct packed {
      logic     access_valid;
      logic     write_access;
      slot_type slot;
      slot_type frames_per_beat;
      logic     rings_rebased;
   } rsp_type;

   typedef struct packed {
      logic [NUM_RINGS-1:0][SLOT_W-1:0] delay;
      logic [MASK_W-1:0]                follow_mask;
      logic                             dirty;
   } cfg_type;

   typedef struct packed {
      logic advance;
      logic reconf;
      logic force_rebase;
      logic geom_ok;
   } step_type;

   typedef struct packed {
      logic     live;
      slot_type len;
      slot_type rd;
      slot_type wr;
   } ring_state_type;

   function automatic slot_type next_slot(slot_type s, slot_type len);
      logic [SLOT_W:0] inc;
      inc = {1'b0, s} + {{SLOT_W{1'b0}}, 1'b1};
      return (inc >= {1'b0, len}) ? '0 : inc[SLOT_W-1:0];
   endfunction

   function automatic slot_type sat_delay(slot_type v);
      return (v > MAX_SLOT) ? MAX_SLOT : v;
   endfunction

endpackage

>>> design/mtfd_if.sv
// mtfd_if: valid/ready channel interfaces for render-call words and
// slot-result words. Depends on mtfd_pkg.

interface mtfd_req_if;
   logic                         valid;
   logic                         ready;
   logic                         new_frame;
   logic                         beat;
   logic                         geometry_changed;
   logic                         geometry_valid;
   mtfd_pkg::cmd_type            cmd;
   logic [mtfd_pkg::SEL_W-1:0]   buffer_sel;

   modport source (output valid, new_frame, beat, geometry_changed, geometry_valid,
                   cmd, buffer_sel, input ready);
   modport sink   (input valid, new_frame, beat, geometry_changed, geometry_valid,
                   cmd, buffer_sel, output ready);
endinterface

interface mtfd_rsp_if;
   logic                valid;
   logic                ready;
   logic                access_valid;
   logic                write_access;
   mtfd_pkg::slot_type  slot;
   mtfd_pkg::slot_type  frames_per_beat;
   logic                rings_rebased;

   modport source (output valid, access_valid, write_access, slot, frames_per_beat,
                   rings_rebased, input ready);
   modport sink   (input valid, access_valid, write_access, slot, frames_per_beat,
                   rings_rebased, output ready);
endinterface

>>> design/multi_tap_frame_delay_slot_control.sv
// multi_tap_frame_delay_slot_control: top level of the frame-delay slot
// controller. Depends on mtfd_pkg, mtfd_if, mtfd_csr, mtfd_beat, mtfd_ring.
//
// usage
//  req_chan carries one word per render call (frame, beat and geometry flags
//  plus a store/fetch/pass request for one ring); rsp_chan returns one word
//  per call with the slot to access, the measured beat period and a re-base
//  flag. Both are valid/ready channels.
//  The APB port sets the six ring delays (word address 4*i) and the beat
//  follow mask (address 24); delay writes are saturated to 400 frames.
//  Writes are to be made while no call is in flight; this is not enforced.
//  An accepted word is held in the input register, processed combinationally
//  and its result is captured in the result register.
//  Throughput: one call per cycle unless rsp_chan stalls; all six rings
//  update in parallel between the input register and the result register.
//  Reset clears all ring pointers, beat counters, config registers and valid
//  flags; the first call after reset is treated as a new frame.
//  When rsp_chan stalls, the result register holds, one more call is taken
//  into the input register, and then req_chan ready drops.

module multi_tap_frame_delay_slot_control (
   input  logic                         clock,
   input  logic                         reset,
   mtfd_req_if.sink                     req_chan,
   mtfd_rsp_if.source                   rsp_chan,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [mtfd_pkg::ADDR_W-1:0]  paddr,
   input  logic [mtfd_pkg::DATA_W-1:0]  pwdata,
   output logic [mtfd_pkg::DATA_W-1:0]  prdata,
   output logic                         pready
);

   logic                                          in_valid_ff;
   mtfd_pkg::req_type                             in_ff;
   logic                                          out_valid_ff;
   mtfd_pkg::rsp_type                             out_ff, rsp_in;
   logic                                          have_frame_ff;
   logic                                          move;
   logic                                          frame_step;
   logic                                          clear_dirty;
   logic                                          hit;
   logic                                          is_req;
   mtfd_pkg::slot_type                            hit_slot;
   mtfd_pkg::slot_type                            period_next;
   mtfd_pkg::step_type                            step;
   mtfd_pkg::cfg_type                             cfg;
   mtfd_pkg::req_type                             req_word;
   mtfd_pkg::ring_state_type [mtfd_pkg::NUM_RINGS-1:0] ring_next;
   logic [mtfd_pkg::NUM_RINGS-1:0]                rebased_vec;

   assign move           = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || move;

   assign req_word.new_frame        = req_chan.new_frame;
   assign req_word.beat             = req_chan.beat;
   assign req_word.geometry_changed = req_chan.geometry_changed;
   assign req_word.geometry_valid   = req_chan.geometry_valid;
   assign req_word.cmd              = req_chan.cmd;
   assign req_word.buffer_sel       = req_chan.buffer_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_ff <= req_word;
      end
   end

   // per-call control
   always_comb begin
      frame_step        = !have_frame_ff || in_ff.new_frame;
      step.advance      = have_frame_ff && in_ff.new_frame;
      step.force_rebase = in_ff.geometry_changed || cfg.dirty;
      step.reconf       = frame_step || step.force_rebase;
      step.geom_ok      = in_ff.geometry_valid;
   end

   assign clear_dirty = move && step.reconf;

   mtfd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .clear_dirty (clear_dirty),
      .cfg         (cfg)
   );

   mtfd_beat u_beat (
      .clock       (clock),
      .reset       (reset),
      .move        (move),
      .frame_step  (frame_step),
      .beat        (in_ff.beat),
      .period_next (period_next)
   );

   for (genvar g = 0; g < mtfd_pkg::NUM_RINGS; g++) begin : g_ring
      mtfd_ring u_ring (
         .clock       (clock),
         .reset       (reset),
         .move        (move),
         .step        (step),
         .follow      (cfg.follow_mask[g]),
         .fixed_delay (cfg.delay[g]),
         .beat_period (period_next),
         .ring_next   (ring_next[g]),
         .rebased     (rebased_vec[g])
      );
   end

   // request lookup on the updated ring state
   always_comb begin
      hit      = 1'b0;
      hit_slot = '0;
      is_req   = (in_ff.cmd == mtfd_pkg::CMD_STORE) || (in_ff.cmd == mtfd_pkg::CMD_FETCH);
      for (int i = 0; i < mtfd_pkg::NUM_RINGS; i++) begin
         if (in_ff.buffer_sel == mtfd_pkg::SEL_W'(i) && ring_next[i].live) begin
            hit      = 1'b1;
            hit_slot = (in_ff.cmd == mtfd_pkg::CMD_STORE) ? ring_next[i].wr : ring_next[i].rd;
         end
      end
      rsp_in.access_valid    = in_ff.geometry_valid && is_req && hit;
      rsp_in.write_access    = rsp_in.access_valid && (in_ff.cmd == mtfd_pkg::CMD_STORE);
      rsp_in.slot            = rsp_in.access_valid ? hit_slot : '0;
      rsp_in.frames_per_beat = period_next;
      rsp_in.rings_rebased   = |rebased_vec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         have_frame_ff <= 1'b0;
      end else begin
         if (move) begin
            out_valid_ff  <= 1'b1;
            have_frame_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         out_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.access_valid    = out_ff.access_valid;
   assign rsp_chan.write_access    = out_ff.write_access;
   assign rsp_chan.slot            = out_ff.slot;
   assign rsp_chan.frames_per_beat = out_ff.frames_per_beat;
   assign rsp_chan.rings_rebased   = out_ff.rings_rebased;

   a_frame_seen : assert property (@(posedge clock) disable iff (reset)
      move |=> have_frame_ff)
      else $error("first call did not mark a frame");

   a_ready_low : assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (in_valid_ff && out_valid_ff))
      else $error("input stalled while pipeline not full");

   a_out_from_in : assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(in_valid_ff))
      else $error("result appeared without a pending call");

endmodule

>>> design/mtfd_csr.sv
// mtfd_csr: APB register file holding the per-ring delays, the beat
// follow mask and the config-changed flag. Depends on mtfd_pkg.

module mtfd_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [mtfd_pkg::ADDR_W-1:0]  paddr,
   input  logic [mtfd_pkg::DATA_W-1:0]  pwdata,
   output logic [mtfd_pkg::DATA_W-1:0]  prdata,
   output logic                         pready,
   input  logic                         clear_dirty,
   output mtfd_pkg::cfg_type            cfg
);

   logic [mtfd_pkg::NUM_RINGS-1:0][mtfd_pkg::SLOT_W-1:0] delay_ff, delay_in;
   logic [mtfd_pkg::MASK_W-1:0]                          mask_ff, mask_in;
   logic                                                 dirty_ff, dirty_in;
   logic                                                 write_en;
   mtfd_pkg::reg_index_type                              idx;
   mtfd_pkg::slot_type                                   wval;
   logic [mtfd_pkg::MASK_W-1:0]                          mval;

   assign write_en = psel && penable && pwrite;
   assign idx      = paddr[mtfd_pkg::ADDR_W-1:2];
   assign wval     = mtfd_pkg::sat_delay(pwdata[mtfd_pkg::SLOT_W-1:0]);
   assign mval     = pwdata[mtfd_pkg::MASK_W-1:0];
   assign pready   = 1'b1;

   always_comb begin
      delay_in = delay_ff;
      mask_in  = mask_ff;
      dirty_in = dirty_ff && !clear_dirty;
      if (write_en) begin
         if (idx < mtfd_pkg::REG_BEAT_FOLLOW_MASK) begin
            if (delay_ff[idx] != wval) begin
               delay_in[idx] = wval;
               dirty_in      = 1'b1;
            end
         end else if (idx == mtfd_pkg::REG_BEAT_FOLLOW_MASK) begin
            if (mask_ff != mval) begin
               mask_in  = mval;
               dirty_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      prdata = '0;
      if (idx < mtfd_pkg::REG_BEAT_FOLLOW_MASK) begin
         prdata = mtfd_pkg::DATA_W'(delay_ff[idx]);
      end else if (idx == mtfd_pkg::REG_BEAT_FOLLOW_MASK) begin
         prdata = mtfd_pkg::DATA_W'(mask_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= '0;
         mask_ff  <= '0;
         dirty_ff <= 1'b0;
      end else begin
         delay_ff <= delay_in;
         mask_ff  <= mask_in;
         dirty_ff <= dirty_in;
      end
   end

   assign cfg.delay       = delay_ff;
   assign cfg.follow_mask = mask_ff;
   assign cfg.dirty       = dirty_ff;

endmodule

>>> design/mtfd_beat.sv
// mtfd_beat: frames-since-beat counter and measured beat period,
// both saturating at the maximum delay. Depends on mtfd_pkg.

module mtfd_beat (
   input  logic                clock,
   input  logic                reset,
   input  logic                move,
   input  logic                frame_step,
   input  logic                beat,
   output mtfd_pkg::slot_type  period_next
);

   mtfd_pkg::slot_type frames_since_ff, frames_since_in;
   mtfd_pkg::slot_type period_ff, period_in;

   always_comb begin
      frames_since_in = frames_since_ff;
      period_in       = period_ff;
      if (frame_step) begin
         if (beat) begin
            period_in       = mtfd_pkg::sat_delay(frames_since_ff);
            frames_since_in = '0;
         end
         if (frames_since_in < mtfd_pkg::MAX_SLOT) begin
            frames_since_in = frames_since_in + mtfd_pkg::slot_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_since_ff <= '0;
         period_ff       <= '0;
      end else if (move) begin
         frames_since_ff <= frames_since_in;
         period_ff       <= period_in;
      end
   end

   assign period_next = period_in;

endmodule

>>> design/mtfd_ring.sv
// mtfd_ring: read/write slot state of one frame ring, with the per-frame
// advance and the length check / re-base logic. Depends on mtfd_pkg.

module mtfd_ring (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       move,
   input  mtfd_pkg::step_type         step,
   input  logic                       follow,
   input  mtfd_pkg::slot_type         fixed_delay,
   input  mtfd_pkg::slot_type         beat_period,
   output mtfd_pkg::ring_state_type   ring_next,
   output logic                       rebased
);

   mtfd_pkg::ring_state_type state_ff, state_in, adv;
   mtfd_pkg::slot_type       dly, len;

   always_comb begin
      adv = state_ff;
      if (step.advance && state_ff.live && state_ff.len > mtfd_pkg::slot_type'(1)) begin
         adv.rd = mtfd_pkg::next_slot(state_ff.rd, state_ff.len);
         adv.wr = mtfd_pkg::next_slot(state_ff.wr, state_ff.len);
      end

      dly = mtfd_pkg::sat_delay(follow ? beat_period : fixed_delay);
      len = dly + mtfd_pkg::slot_type'(1);

      state_in = adv;
      rebased  = 1'b0;
      if (step.reconf) begin
         if (!step.geom_ok || dly == '0) begin
            state_in.live = 1'b0;
            state_in.len  = len;
            state_in.rd   = '0;
            state_in.wr   = dly;
         end else if (step.force_rebase || !adv.live || adv.len != len) begin
            state_in.live = 1'b1;
            state_in.len  = len;
            state_in.rd   = '0;
            state_in.wr   = dly;
            rebased       = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (move) begin
         state_ff <= state_in;
      end
   end

   assign ring_next = state_in;

endmodule

>>> tb/tb.sv
// tb: self-checking bench for the frame-delay slot controller; predicts every
// slot word from render calls and register writes and compares field by field.
// Depends on mtfd_pkg, mtfd_if and multi_tap_frame_delay_slot_control.

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mtfd_pkg::*;

   localparam cmd_type       CMD_PASS  = 2'd0;
   localparam cmd_type       CMD_SPARE = 2'd3;
   localparam reg_index_type REG_SPARE = REG_BEAT_FOLLOW_MASK + 1'b1;

   logic              clock;
   logic              reset = 1'b1;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   mtfd_req_if req_chan ();
   mtfd_rsp_if rsp_chan ();

   multi_tap_frame_delay_slot_control u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // predicted block state
   slot_type          delay_q [NUM_RINGS];
   logic [MASK_W-1:0] follow_q;
   bit                cfg_changed;
   slot_type          ring_len [NUM_RINGS];
   slot_type          rd_slot [NUM_RINGS];
   slot_type          wr_slot [NUM_RINGS];
   bit                ring_up [NUM_RINGS];
   bit                seen_frame;
   slot_type          since_beat;
   slot_type          beat_per;

   rsp_type pending_slots [$];

   int send_idle_pct;
   int recv_stall_pct;
   int stall_left;
   int calls_sent;
   int words_checked;
   int csr_writes;
   int bad_fields;
   int fail_count;
   int phases_run;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   initial begin
      #10_000_000;
      $display("tb: FAIL");
      $finish;
   end

   function automatic bit rebuild_rings(bit geom_ok, bit force_all);
      bit any;
      int d;
      int len;
      any = 1'b0;
      for (int i = 0; i < NUM_RINGS; i++) begin
         d = follow_q[i] ? int'(beat_per) : int'(delay_q[i]);
         if (d > MAX_DELAY) d = MAX_DELAY;
         len = d + 1;
         if (!geom_ok || len <= 1) begin
            ring_up[i]  = 1'b0;
            ring_len[i] = slot_type'(len);
            rd_slot[i]  = '0;
            wr_slot[i]  = slot_type'(len - 1);
            continue;
         end
         if (!force_all && ring_up[i] && int'(ring_len[i]) == len) continue;
         ring_up[i]  = 1'b1;
         ring_len[i] = slot_type'(len);
         rd_slot[i]  = '0;
         wr_slot[i]  = slot_type'(len - 1);
         any = 1'b1;
      end
      return any;
   endfunction

   function automatic rsp_type predict_slot_answer(req_type w);
      rsp_type r;
      bit rebased;
      r = '0;
      rebased = 1'b0;
      if (!seen_frame || w.new_frame) begin
         if (seen_frame) begin
            for (int i = 0; i < NUM_RINGS; i++) begin
               if (!ring_up[i] || ring_len[i] <= 1) continue;
               rd_slot[i] = (int'(rd_slot[i]) + 1 >= int'(ring_len[i])) ? '0 : rd_slot[i] + 1'b1;
               wr_slot[i] = (int'(wr_slot[i]) + 1 >= int'(ring_len[i])) ? '0 : wr_slot[i] + 1'b1;
            end
         end
         seen_frame = 1'b1;
         if (w.beat) begin
            beat_per   = (since_beat < MAX_DELAY) ? since_beat : slot_type'(MAX_DELAY);
            since_beat = '0;
         end
         if (since_beat < MAX_DELAY) since_beat = since_beat + 1'b1;
         rebased = rebuild_rings(w.geometry_valid, w.geometry_changed || cfg_changed);
         cfg_changed = 1'b0;
      end else if (w.geometry_changed || cfg_changed) begin
         rebased = rebuild_rings(w.geometry_valid, 1'b1);
         cfg_changed = 1'b0;
      end
      if (w.geometry_valid && (w.cmd == CMD_STORE || w.cmd == CMD_FETCH) &&
          w.buffer_sel < NUM_RINGS && ring_up[w.buffer_sel]) begin
         r.access_valid = 1'b1;
         r.write_access = (w.cmd == CMD_STORE);
         r.slot = (w.cmd == CMD_STORE) ? wr_slot[w.buffer_sel] : rd_slot[w.buffer_sel];
      end
      r.frames_per_beat = beat_per;
      r.rings_rebased   = rebased;
      return r;
   endfunction

   function automatic req_type make_call(bit nf, bit bt, bit gc, bit gv, cmd_type c, int sel);
      req_type w;
      w.new_frame        = nf;
      w.beat             = bt;
      w.geometry_changed = gc;
      w.geometry_valid   = gv;
      w.cmd              = c;
      w.buffer_sel       = SEL_W'(sel);
      return w;
   endfunction

   function automatic req_type make_random_call();
      req_type w;
      int r;
      w.new_frame        = ($urandom_range(99) < 60);
      w.beat             = ($urandom_range(99) < 12);
      w.geometry_changed = ($urandom_range(99) < 4);
      w.geometry_valid   = ($urandom_range(99) < 93);
      r = $urandom_range(99);
      w.cmd = (r < 40) ? CMD_STORE : (r < 80) ? CMD_FETCH : (r < 92) ? CMD_PASS : CMD_SPARE;
      w.buffer_sel = ($urandom_range(99) < 92) ? SEL_W'($urandom_range(0, NUM_RINGS - 1))
                                               : SEL_W'($urandom_range(NUM_RINGS, 7));
      return w;
   endfunction

   function automatic int pick_gap(int pct);
      if ($urandom_range(99) >= pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(20, 60);
      return $urandom_range(1, 3);
   endfunction

   function automatic void note_mismatch(string what, logic [8:0] want, logic [8:0] got);
      if (bad_fields < 10)
         $display("tb: mismatch on %s at %0t: expected %0d, got %0d", what, $time, want, got);
      bad_fields++;
      fail_count++;
   endfunction

   // valid stays high after a word is taken so back-to-back words need no gap
   task automatic send_call(req_type w);
      int gap;
      gap = pick_gap(send_idle_pct);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid            <= 1'b1;
      req_chan.new_frame        <= w.new_frame;
      req_chan.beat             <= w.beat;
      req_chan.geometry_changed <= w.geometry_changed;
      req_chan.geometry_valid   <= w.geometry_valid;
      req_chan.cmd              <= w.cmd;
      req_chan.buffer_sel       <= w.buffer_sel;
      do @(posedge clock); while (!req_chan.ready);
      pending_slots.push_back(predict_slot_answer(w));
      calls_sent++;
   endtask

   task automatic settle_block();
      int guard;
      guard = 0;
      req_chan.valid <= 1'b0;
      while (pending_slots.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, slot_type value);
      logic [DATA_W-1:0] data;
      logic [8:0]        v;
      data = $urandom();
      if (idx == REG_BEAT_FOLLOW_MASK) data[MASK_W-1:0] = value[MASK_W-1:0];
      else data[SLOT_W-1:0] = value;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      csr_writes++;
      if (idx < REG_BEAT_FOLLOW_MASK) begin
         v = data[SLOT_W-1:0];
         if (v > MAX_DELAY) v = MAX_DELAY;
         if (delay_q[idx] != v) begin
            delay_q[idx] = v;
            cfg_changed = 1'b1;
         end
      end else if (idx == REG_BEAT_FOLLOW_MASK) begin
         if (follow_q != data[MASK_W-1:0]) begin
            follow_q = data[MASK_W-1:0];
            cfg_changed = 1'b1;
         end
      end
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if ($urandom_range(99) < recv_stall_pct) begin
         stall_left <= ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = {rsp_chan.access_valid, rsp_chan.write_access, rsp_chan.slot,
                rsp_chan.frames_per_beat, rsp_chan.rings_rebased};
         if (pending_slots.size() == 0) begin
            note_mismatch("unexpected word slot", '0, got.slot);
         end else begin
            want = pending_slots.pop_front();
            words_checked++;
            if (got.access_valid !== want.access_valid)
               note_mismatch("access_valid", want.access_valid, got.access_valid);
            if (got.write_access !== want.write_access)
               note_mismatch("write_access", want.write_access, got.write_access);
            if (got.slot !== want.slot)
               note_mismatch("slot", want.slot, got.slot);
            if (got.frames_per_beat !== want.frames_per_beat)
               note_mismatch("frames_per_beat", want.frames_per_beat, got.frames_per_beat);
            if (got.rings_rebased !== want.rings_rebased)
               note_mismatch("rings_rebased", want.rings_rebased, got.rings_rebased);
         end
      end
   end

   task automatic test_first_call();
      send_call(make_call(0, 0, 0, 1, CMD_STORE, 0));
      send_call(make_call(0, 1, 0, 1, CMD_FETCH, 5));
      send_call(make_call(1, 0, 0, 1, CMD_SPARE, 7));
   endtask

   task automatic test_fixed_delays();
      slot_type d [NUM_RINGS];
      d = '{9'd1, 9'd2, 9'd3, 9'd400, 9'd0, 9'd511};
      settle_block();
      for (int i = 0; i < NUM_RINGS; i++) csr_write(reg_index_type'(i), d[i]);
      csr_write(REG_BEAT_FOLLOW_MASK, '0);
      send_call(make_call(0, 0, 0, 1, CMD_STORE, 0));
      send_call(make_call(0, 0, 0, 1, CMD_FETCH, 3));
      send_call(make_call(1, 0, 0, 1, CMD_STORE, 3));
      send_call(make_call(1, 0, 0, 1, CMD_FETCH, 0));
      send_call(make_call(1, 0, 0, 1, CMD_STORE, 1));
      send_call(make_call(0, 0, 0, 1, CMD_FETCH, 4));
      send_call(make_call(0, 0, 0, 1, CMD_STORE, 6));
      send_call(make_call(0, 0, 0, 1, CMD_FETCH, 7));
      send_call(make_call(0, 0, 0, 1, CMD_SPARE, 2));
      send_call(make_call(0, 0, 0, 1, CMD_PASS, 2));
      send_call(make_call(1, 0, 0, 0, CMD_STORE, 2));
      send_call(make_call(0, 0, 1, 1, CMD_FETCH, 2));
      send_call(make_call(1, 0, 1, 1, CMD_STORE, 5));
   endtask

   task automatic test_beat_follow();
      settle_block();
      csr_write(REG_BEAT_FOLLOW_MASK, 9'h2A);
      for (int k = 0; k < 12; k++)
         send_call(make_call(1, (k == 3 || k == 8), 0, 1,
                             (k % 2) ? CMD_FETCH : CMD_STORE, k % NUM_RINGS));
      send_call(make_call(0, 1, 0, 1, CMD_FETCH, 1));
   endtask

   // long beatless run: counter saturates, ring 1 wraps through its top slot
   task automatic test_beat_saturation();
      settle_block();
      csr_write(REG_BEAT_FOLLOW_MASK, 9'h01);
      csr_write(reg_index_type'(1), 9'd400);
      for (int k = 0; k < 410; k++)
         send_call(make_call(1, 0, 0, 1, (k % 2) ? CMD_FETCH : CMD_STORE, 1));
      send_call(make_call(1, 1, 0, 1, CMD_FETCH, 0));
      send_call(make_call(1, 0, 0, 1, CMD_STORE, 0));
      send_call(make_call(0, 0, 0, 1, CMD_FETCH, 0));
   endtask

   task automatic test_random_phases();
      slot_type d;
      req_type  w;
      for (int p = 0; p < 8; p++) begin
         settle_block();
         for (int i = 0; i < NUM_RINGS; i++) begin
            case (p)
               0: d = '0;
               1: d = 9'd511;
               2: d = 9'd400;
               default: d = ($urandom_range(9) == 0) ? slot_type'($urandom_range(0, 511))
                                                     : slot_type'($urandom_range(0, 6));
            endcase
            csr_write(reg_index_type'(i), d);
         end
         case (p)
            0, 2: csr_write(REG_BEAT_FOLLOW_MASK, 9'h3F);
            1: csr_write(REG_BEAT_FOLLOW_MASK, '0);
            default: csr_write(REG_BEAT_FOLLOW_MASK, slot_type'($urandom_range(0, 63)));
         endcase
         if (p == 4) csr_write(REG_SPARE, slot_type'($urandom_range(0, 511)));
         send_idle_pct  = (p == 3) ? 0 : 25;
         recv_stall_pct = (p == 3) ? 0 : (p == 5) ? 60 : 25;
         for (int k = 0; k < 50; k++) begin
            if (p >= 6 && $urandom_range(99) < 30) w = req_type'($urandom());
            else w = make_random_call();
            send_call(w);
         end
         phases_run++;
      end
   endtask

   initial begin
      req_chan.valid            = 1'b0;
      req_chan.new_frame        = 1'b0;
      req_chan.beat             = 1'b0;
      req_chan.geometry_changed = 1'b0;
      req_chan.geometry_valid   = 1'b0;
      req_chan.cmd              = CMD_PASS;
      req_chan.buffer_sel       = '0;
      rsp_chan.ready            = 1'b1;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      stall_left     = 0;
      send_idle_pct  = 20;
      recv_stall_pct = 20;
      for (int i = 0; i < NUM_RINGS; i++) begin
         delay_q[i]  = '0;
         ring_len[i] = '0;
         rd_slot[i]  = '0;
         wr_slot[i]  = '0;
         ring_up[i]  = 1'b0;
      end
      follow_q    = '0;
      cfg_changed = 1'b0;
      seen_frame  = 1'b0;
      since_beat  = '0;
      beat_per    = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_first_call();
      test_fixed_delays();
      test_beat_follow();
      test_beat_saturation();
      test_random_phases();

      settle_block();
      fail_count += pending_slots.size();
      $display("tb: %0d render calls sent, %0d slot words checked, %0d register writes",
               calls_sent, words_checked, csr_writes);
      $display("tb: fixed and beat-following delays, beat counter saturation, %0d random phases",
               phases_run);
      if (fail_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
